@@ rtl/ffal_pkg.sv @@
// Shared constants, sequencer commands and status flags for the free-list allocator.
package ffal_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;

    localparam logic [DATA_W-1:0] PAGE_ADD  = 32'h0000_0fff;
    localparam logic [DATA_W-1:0] PAGE_MASK = 32'hffff_f000;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Operations that the controller hands to the datapath, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_NEXT,
        OP_ALLOC_HIT,
        OP_ALLOC_MISS,
        OP_READ_UP,
        OP_WR_DOWN,
        OP_DEC_COUNT,
        OP_MERGE_BOTH,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_INS_START,
        OP_READ_DOWN,
        OP_WR_UP,
        OP_INS_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic at_end;
        logic fit;
        logic empty_left;
        logic above_addr;
        logic merge_prev;
        logic merge_next;
        logic full;
        logic rm_more;
        logic ins_more;
    } dp_status_t;

endpackage

@@ rtl/first_fit_free_list_allocator_top.sv @@
// First-fit free-list allocator with coalescing: top level.
// A request word is taken when start is high and busy is low; busy then stays
// high until done, high for exactly one cycle, marks the result word on the
// result ports, and the receiver cannot hold it off. The list lives in two
// memories of ENTRIES start and length entries with one read and one write per
// cycle, so a request walks the list one entry at a time through S_SCAN, S_RD
// and S_CHK, and each entry moved when a region is removed or inserted passes
// through S_RM, S_RM_RD and S_RM_WR or S_INS, S_INS_RD and S_INS_WR. The list
// is empty after reset and no clearing pass runs.
module first_fit_free_list_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [ffal_pkg::DATA_W-1:0] block_addr,
    input  logic [ffal_pkg::DATA_W-1:0] block_size,
    input  logic                        page_round,
    output logic                        done,
    output logic [ffal_pkg::DATA_W-1:0] alloc_addr,
    output logic                        status,
    output logic [ffal_pkg::DATA_W-1:0] total_free,
    output logic [ffal_pkg::CNT_W-1:0]  entries_used,
    output logic [ffal_pkg::CNT_W-1:0]  peak_entries,
    output logic [ffal_pkg::DATA_W-1:0] failed_frees,
    output logic [ffal_pkg::DATA_W-1:0] lost_bytes
);

    ffal_pkg::dp_cmd_t    cmd;
    ffal_pkg::dp_status_t stat;

    ffal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ffal_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .block_addr   (block_addr),
        .block_size   (block_size),
        .page_round   (page_round),
        .done         (done),
        .alloc_addr   (alloc_addr),
        .status       (status),
        .total_free   (total_free),
        .entries_used (entries_used),
        .peak_entries (peak_entries),
        .failed_frees (failed_frees),
        .lost_bytes   (lost_bytes)
    );

endmodule

@@ rtl/ffal_dp.sv @@
// Datapath: region memories, scan index, working registers and statistics.
module ffal_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffal_pkg::dp_cmd_t             cmd,
    output ffal_pkg::dp_status_t          stat,
    input  logic                          action,
    input  logic [ffal_pkg::DATA_W-1:0]   block_addr,
    input  logic [ffal_pkg::DATA_W-1:0]   block_size,
    input  logic                          page_round,
    output logic                          done,
    output logic [ffal_pkg::DATA_W-1:0]   alloc_addr,
    output logic                          status,
    output logic [ffal_pkg::DATA_W-1:0]   total_free,
    output logic [ffal_pkg::CNT_W-1:0]    entries_used,
    output logic [ffal_pkg::CNT_W-1:0]    peak_entries,
    output logic [ffal_pkg::DATA_W-1:0]   failed_frees,
    output logic [ffal_pkg::DATA_W-1:0]   lost_bytes
);

    logic [ffal_pkg::DATA_W-1:0] mem_start [ffal_pkg::ENTRIES];
    logic [ffal_pkg::DATA_W-1:0] mem_len   [ffal_pkg::ENTRIES];

    logic                        act_reg;
    logic [ffal_pkg::DATA_W-1:0] addr_reg;
    logic [ffal_pkg::DATA_W-1:0] size_reg;
    logic [ffal_pkg::CNT_W-1:0]  idx_reg;
    logic [ffal_pkg::CNT_W-1:0]  pos_reg;
    logic [ffal_pkg::DATA_W-1:0] rd_start_reg;
    logic [ffal_pkg::DATA_W-1:0] rd_len_reg;
    logic [ffal_pkg::DATA_W-1:0] prev_start_reg;
    logic [ffal_pkg::DATA_W-1:0] prev_len_reg;
    logic [ffal_pkg::CNT_W-1:0]  count_reg;
    logic [ffal_pkg::CNT_W-1:0]  peak_reg;
    logic [ffal_pkg::DATA_W-1:0] drop_cnt_reg;
    logic [ffal_pkg::DATA_W-1:0] drop_bytes_reg;
    logic [ffal_pkg::DATA_W-1:0] total_reg;
    logic [ffal_pkg::DATA_W-1:0] res_addr_reg;
    logic                        res_status_reg;
    logic                        done_reg;

    logic [ffal_pkg::CNT_W-1:0]  idx_p1;
    logic [ffal_pkg::CNT_W-1:0]  idx_m1;
    logic [ffal_pkg::CNT_W-1:0]  count_p1;
    logic [ffal_pkg::DATA_W-1:0] size_in;
    logic                        rd_en;
    logic [ffal_pkg::IDX_W-1:0]  rd_idx;
    logic                        wr_en;
    logic [ffal_pkg::IDX_W-1:0]  wr_idx;
    logic [ffal_pkg::DATA_W-1:0] wr_start;
    logic [ffal_pkg::DATA_W-1:0] wr_len;

    assign idx_p1   = idx_reg + ffal_pkg::CNT_W'(1);
    assign idx_m1   = idx_reg - ffal_pkg::CNT_W'(1);
    assign count_p1 = count_reg + ffal_pkg::CNT_W'(1);
    assign size_in  = page_round ? ((block_size + ffal_pkg::PAGE_ADD) & ffal_pkg::PAGE_MASK)
                                 : block_size;

    // Status flags for the controller.
    always_comb
    begin
        stat.is_free    = (act_reg == ffal_pkg::ACT_FREE);
        stat.at_end     = (idx_reg == count_reg);
        stat.fit        = (rd_len_reg >= size_reg);
        stat.empty_left = (rd_len_reg == size_reg);
        stat.above_addr = (rd_start_reg > addr_reg);
        stat.merge_prev = (idx_reg != '0) && (prev_start_reg + prev_len_reg == addr_reg);
        stat.merge_next = (idx_reg < count_reg) && (addr_reg + size_reg == rd_start_reg);
        stat.full       = (count_reg == ffal_pkg::CNT_W'(ffal_pkg::ENTRIES));
        stat.rm_more    = (idx_p1 < count_reg);
        stat.ins_more   = (idx_reg > pos_reg);
    end

    // Memory port selection.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_idx   = idx_reg[ffal_pkg::IDX_W-1:0];
        wr_en    = 1'b0;
        wr_idx   = idx_reg[ffal_pkg::IDX_W-1:0];
        wr_start = rd_start_reg;
        wr_len   = rd_len_reg;
        case (cmd.op)
            ffal_pkg::OP_READ:
            begin
                rd_en = 1'b1;
            end
            ffal_pkg::OP_READ_UP:
            begin
                rd_en  = 1'b1;
                rd_idx = idx_p1[ffal_pkg::IDX_W-1:0];
            end
            ffal_pkg::OP_READ_DOWN:
            begin
                rd_en  = 1'b1;
                rd_idx = idx_m1[ffal_pkg::IDX_W-1:0];
            end
            ffal_pkg::OP_ALLOC_HIT:
            begin
                wr_en    = 1'b1;
                wr_start = rd_start_reg + size_reg;
                wr_len   = rd_len_reg - size_reg;
            end
            ffal_pkg::OP_WR_DOWN, ffal_pkg::OP_WR_UP:
            begin
                wr_en = 1'b1;
            end
            ffal_pkg::OP_MERGE_BOTH:
            begin
                wr_en    = 1'b1;
                wr_idx   = idx_m1[ffal_pkg::IDX_W-1:0];
                wr_start = prev_start_reg;
                wr_len   = prev_len_reg + size_reg + rd_len_reg;
            end
            ffal_pkg::OP_MERGE_PREV:
            begin
                wr_en    = 1'b1;
                wr_idx   = idx_m1[ffal_pkg::IDX_W-1:0];
                wr_start = prev_start_reg;
                wr_len   = prev_len_reg + size_reg;
            end
            ffal_pkg::OP_MERGE_NEXT:
            begin
                wr_en    = 1'b1;
                wr_start = addr_reg;
                wr_len   = rd_len_reg + size_reg;
            end
            ffal_pkg::OP_INS_WR:
            begin
                wr_en    = 1'b1;
                wr_start = addr_reg;
                wr_len   = size_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Region memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_idx] <= wr_start;
            mem_len[wr_idx]   <= wr_len;
        end
        if (rd_en)
        begin
            rd_start_reg <= mem_start[rd_idx];
            rd_len_reg   <= mem_len[rd_idx];
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ffal_pkg::OP_LOAD:
            begin
                act_reg      <= action;
                addr_reg     <= block_addr;
                size_reg     <= size_in;
                res_addr_reg <= '0;
            end
            ffal_pkg::OP_NEXT:
            begin
                prev_start_reg <= rd_start_reg;
                prev_len_reg   <= rd_len_reg;
            end
            ffal_pkg::OP_ALLOC_HIT:
            begin
                res_addr_reg <= rd_start_reg;
            end
            ffal_pkg::OP_INS_START:
            begin
                pos_reg <= idx_reg;
            end
            default:
            begin
                res_addr_reg <= res_addr_reg;
            end
        endcase
    end

    // Control state and statistics.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            count_reg      <= '0;
            peak_reg       <= '0;
            total_reg      <= '0;
            res_status_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            case (cmd.op)
                ffal_pkg::OP_LOAD:
                begin
                    idx_reg        <= '0;
                    res_status_reg <= 1'b0;
                end
                ffal_pkg::OP_NEXT, ffal_pkg::OP_WR_DOWN:
                begin
                    idx_reg <= idx_p1;
                end
                ffal_pkg::OP_WR_UP:
                begin
                    idx_reg <= idx_m1;
                end
                ffal_pkg::OP_ALLOC_HIT:
                begin
                    total_reg <= total_reg - size_reg;
                end
                ffal_pkg::OP_ALLOC_MISS:
                begin
                    res_status_reg <= 1'b1;
                end
                ffal_pkg::OP_DEC_COUNT:
                begin
                    count_reg <= count_reg - ffal_pkg::CNT_W'(1);
                end
                ffal_pkg::OP_MERGE_BOTH, ffal_pkg::OP_MERGE_PREV, ffal_pkg::OP_MERGE_NEXT:
                begin
                    total_reg <= total_reg + size_reg;
                end
                ffal_pkg::OP_INS_START:
                begin
                    idx_reg <= count_reg;
                end
                ffal_pkg::OP_INS_WR:
                begin
                    total_reg <= total_reg + size_reg;
                    count_reg <= count_p1;
                    if (peak_reg < count_p1)
                    begin
                        peak_reg <= count_p1;
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Drop statistics, taken when a free finds the list full.
    logic drop_now;
    assign drop_now = (cmd.op == ffal_pkg::OP_ALLOC_MISS) && stat.is_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_cnt_reg   <= '0;
            drop_bytes_reg <= '0;
        end
        else if (drop_now)
        begin
            drop_cnt_reg   <= drop_cnt_reg + ffal_pkg::DATA_W'(1);
            drop_bytes_reg <= drop_bytes_reg + size_reg;
        end
    end

    assign done         = done_reg;
    assign alloc_addr   = res_addr_reg;
    assign status       = res_status_reg;
    assign total_free   = total_reg;
    assign entries_used = count_reg;
    assign peak_entries = peak_reg;
    assign failed_frees = drop_cnt_reg;
    assign lost_bytes   = drop_bytes_reg;

endmodule

@@ rtl/ffal_ctrl.sv @@
// Controller: sequences scan, merge, insert and remove steps for one request.
module ffal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffal_pkg::dp_status_t stat,
    output ffal_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_CHK,
        S_RESOLVE,
        S_RM,
        S_RM_RD,
        S_RM_WR,
        S_INS,
        S_INS_RD,
        S_INS_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ffal_pkg::OP_NONE;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = ffal_pkg::OP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.at_end)
                begin
                    if (stat.is_free)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        cmd.op     = ffal_pkg::OP_ALLOC_MISS;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.op     = ffal_pkg::OP_READ;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.is_free)
                begin
                    if (stat.above_addr)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        cmd.op     = ffal_pkg::OP_NEXT;
                        state_next = S_SCAN;
                    end
                end
                else if (stat.fit)
                begin
                    cmd.op     = ffal_pkg::OP_ALLOC_HIT;
                    state_next = stat.empty_left ? S_RM : S_DONE;
                end
                else
                begin
                    cmd.op     = ffal_pkg::OP_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_RESOLVE:
            begin
                if (stat.merge_prev && stat.merge_next)
                begin
                    cmd.op     = ffal_pkg::OP_MERGE_BOTH;
                    state_next = S_RM;
                end
                else if (stat.merge_prev)
                begin
                    cmd.op     = ffal_pkg::OP_MERGE_PREV;
                    state_next = S_DONE;
                end
                else if (stat.merge_next)
                begin
                    cmd.op     = ffal_pkg::OP_MERGE_NEXT;
                    state_next = S_DONE;
                end
                else if (!stat.full)
                begin
                    cmd.op     = ffal_pkg::OP_INS_START;
                    state_next = S_INS;
                end
                else
                begin
                    // List full: the free is dropped and counted.
                    cmd.op     = ffal_pkg::OP_ALLOC_MISS;
                    cmd.finish = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_RM:
            begin
                if (stat.rm_more)
                begin
                    cmd.op     = ffal_pkg::OP_READ_UP;
                    state_next = S_RM_RD;
                end
                else
                begin
                    cmd.op     = ffal_pkg::OP_DEC_COUNT;
                    state_next = S_DONE;
                end
            end
            S_RM_RD:
            begin
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                cmd.op     = ffal_pkg::OP_WR_DOWN;
                state_next = S_RM;
            end
            S_INS:
            begin
                if (stat.ins_more)
                begin
                    cmd.op     = ffal_pkg::OP_READ_DOWN;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.op     = ffal_pkg::OP_INS_WR;
                    state_next = S_DONE;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.op     = ffal_pkg::OP_WR_UP;
                state_next = S_INS;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/ffal_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
module ffal_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [ffal_pkg::CNT_W-1:0] entries_used,
    input logic [ffal_pkg::CNT_W-1:0] peak_entries
);

    // A result word only appears once the request has finished.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // When done is high, the peak is not below the current count.
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entries_used <= peak_entries))
        else $error("entry count above peak");

    // The peak never exceeds the list size.
    a_peak_max: assert property (@(posedge clk) disable iff (!rst_n)
        peak_entries <= ffal_pkg::CNT_W'(ffal_pkg::ENTRIES))
        else $error("peak above list size");

endmodule

bind first_fit_free_list_allocator_top ffal_checker u_ffal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .entries_used (entries_used),
    .peak_entries (peak_entries)
);
